// ----- src/rrtr_pkg.sv -----
// ----------------------------------------------------------------------------
// rrtr_pkg
// Shared types and constants for the round robin task ring unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtr_pkg;

    localparam int NUM_TASKS = 16;
    localparam int TASK_W    = 4;
    localparam int SLOT_W    = $clog2(NUM_TASKS);

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_RUNNABLE = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_YIELD    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_NOOP  = 2'd1,
        STS_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [TASK_W-1:0]   task_id;
    } in_t;

    typedef struct packed {
        logic [TASK_W-1:0]   current_task;
        logic                ring_nonempty;
        status_t             status;
    } out_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SINGLE,
        CMD_SCHED,
        CMD_INS_A,
        CMD_INS_B,
        CMD_CAPTURE,
        CMD_UNLINK
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    load_out;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    task_ok;
        logic    linked;
        logic    ring_valid;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/rrtr_datapath.sv -----
// ----------------------------------------------------------------------------
// rrtr_datapath
// Ring tables, membership bits, current pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtr_datapath
    import rrtr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire in_t        s_data,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      sts,
    output out_t            m_data
);

    logic [TASK_W-1:0] next_mem [NUM_TASKS];
    logic [TASK_W-1:0] prev_mem [NUM_TASKS];

    logic [NUM_TASKS-1:0] in_ring_reg, in_ring_next;
    logic [TASK_W-1:0]    cur_reg, cur_next;
    logic                 valid_reg, valid_next;

    opcode_t              op_reg;
    logic [TASK_W-1:0]    task_reg;
    logic                 ok_reg;
    logic                 linked_reg;
    logic [TASK_W-1:0]    succ_reg;
    logic [TASK_W-1:0]    pred_reg;
    logic [TASK_W-1:0]    link_reg;
    logic [TASK_W-1:0]    next_q;
    logic [TASK_W-1:0]    prev_q;
    out_t                 out_reg;

    logic                 in_ok;
    logic [SLOT_W-1:0]    next_raddr;
    logic                 next_we, prev_we;
    logic [SLOT_W-1:0]    next_waddr, prev_waddr;
    logic [TASK_W-1:0]    next_wdata, prev_wdata;

    assign in_ok = ({1'b0, s_data.task_id} < (TASK_W+1)'(NUM_TASKS));
    assign next_raddr = (cmd.op == CMD_CAPTURE) ? task_reg[SLOT_W-1:0] : cur_reg[SLOT_W-1:0];

    always_comb begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        next_waddr = task_reg[SLOT_W-1:0];
        prev_waddr = task_reg[SLOT_W-1:0];
        next_wdata = task_reg;
        prev_wdata = task_reg;
        in_ring_next = in_ring_reg;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        case (cmd.op)
            CMD_SINGLE: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                in_ring_next[task_reg[SLOT_W-1:0]] = 1'b1;
                cur_next   = task_reg;
                valid_next = 1'b1;
            end
            CMD_SCHED: begin
                cur_next = next_q;
            end
            CMD_INS_A: begin
                next_we    = 1'b1;
                next_wdata = next_q;
                prev_we    = 1'b1;
                prev_wdata = cur_reg;
                in_ring_next[task_reg[SLOT_W-1:0]] = 1'b1;
            end
            CMD_INS_B: begin
                next_we    = 1'b1;
                next_waddr = cur_reg[SLOT_W-1:0];
                prev_we    = 1'b1;
                prev_waddr = link_reg[SLOT_W-1:0];
            end
            CMD_UNLINK: begin
                next_we    = 1'b1;
                next_waddr = pred_reg[SLOT_W-1:0];
                next_wdata = next_q;
                prev_we    = 1'b1;
                prev_waddr = next_q[SLOT_W-1:0];
                prev_wdata = pred_reg;
                in_ring_next[task_reg[SLOT_W-1:0]] = 1'b0;
                if (cur_reg == task_reg) begin
                    if (succ_reg == task_reg) begin
                        valid_next = 1'b0;
                        cur_next   = '0;
                    end else begin
                        cur_next = succ_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ring_reg <= '0;
            cur_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            in_ring_reg <= in_ring_next;
            cur_reg     <= cur_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        next_q <= next_mem[next_raddr];
        prev_q <= prev_mem[task_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_LOAD) begin
            op_reg     <= s_data.opcode;
            task_reg   <= s_data.task_id;
            ok_reg     <= in_ok;
            linked_reg <= in_ok && in_ring_reg[s_data.task_id[SLOT_W-1:0]];
        end
        if (cmd.op == CMD_INS_A) begin
            link_reg <= next_q;
        end
        if (cmd.op == CMD_CAPTURE) begin
            succ_reg <= next_q;
            pred_reg <= prev_q;
        end
        if (cmd.load_out) begin
            out_reg.current_task  <= valid_reg ? cur_reg : '0;
            out_reg.ring_nonempty <= valid_reg;
            out_reg.status        <= cmd.status;
        end
    end

    assign sts.opcode     = op_reg;
    assign sts.task_ok    = ok_reg;
    assign sts.linked     = linked_reg;
    assign sts.ring_valid = valid_reg;
    assign m_data         = out_reg;

endmodule

`default_nettype wire

// ----- src/rrtr_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrtr_ctrl
// Sequencer for one ring operation and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtr_ctrl
    import rrtr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t sts,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCHED,
        S_INS_A,
        S_INS_B,
        S_RM_CAP,
        S_UNLINK,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    m_valid_reg, m_valid_next;
    logic    out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = CMD_NONE;
        cmd.load_out = 1'b0;
        cmd.status   = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                status_next = STS_DONE;
                state_next  = S_DONE;
                case (sts.opcode)
                    OP_SCHEDULE: begin
                        if (sts.ring_valid) begin
                            state_next = S_SCHED;
                        end else begin
                            status_next = STS_NOOP;
                        end
                    end
                    OP_RUNNABLE: begin
                        if (!sts.task_ok || sts.linked) begin
                            status_next = STS_NOOP;
                        end else if (!sts.ring_valid) begin
                            cmd.op = CMD_SINGLE;
                        end else begin
                            state_next = S_INS_A;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.linked) begin
                            state_next = S_RM_CAP;
                        end else begin
                            status_next = STS_NOOP;
                        end
                    end
                    default: begin
                        status_next = sts.linked ? STS_DONE : STS_ERROR;
                    end
                endcase
            end
            S_SCHED: begin
                cmd.op     = CMD_SCHED;
                state_next = S_DONE;
            end
            S_INS_A: begin
                cmd.op     = CMD_INS_A;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                cmd.op     = CMD_INS_B;
                state_next = S_DONE;
            end
            S_RM_CAP: begin
                cmd.op     = CMD_CAPTURE;
                state_next = S_UNLINK;
            end
            S_UNLINK: begin
                cmd.op     = CMD_UNLINK;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= STS_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/round_robin_task_ring_unit.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_ring_unit
// Round robin scheduler ring of task slots kept as linked successor and
// predecessor tables with a current pointer.
//
// s_data carries one operation (schedule, make runnable, remove, yield) and
// a task id; each accepted transaction returns exactly one m_data result
// with the current task after the operation, a ring-not-empty flag and a
// status code.
// After the accepting edge the sequencer passes S_DECIDE, then S_SCHED for
// schedule, S_INS_A and S_INS_B for make runnable on a non-empty ring or
// S_RM_CAP and S_UNLINK for remove, then S_DONE, which loads the result and
// raises m_valid; s_ready rises at the same edge as m_valid. The steps are
// set by the single write and registered read port of each ring table.
// Reset (aresetn low, synchronous) empties the ring and clears all
// membership bits; the tables themselves are not cleared.
// While the receiver stalls, the result is held in the output register;
// one further transaction is accepted and worked on, and its result waits
// until the held one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_ring_unit
    import rrtr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    rrtr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rrtr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- dv/tb_round_robin_task_ring_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_ring_unit
// Self-checking testbench for the round robin task ring unit.
//
// Operations go in through the s_ channel one transaction at a time. A local
// copy of the ring (successor and predecessor tables, membership bits and
// the current pointer) works out the result of each accepted transaction,
// and every m_ transaction is checked field by field, in order, against it.
// A short directed set covers empty and one-task rings, duplicates and
// absent tasks; after that come full-ring sweeps and long random traffic,
// with random idling on both sides, an output stall that fills the block,
// and a pause on the input until all results are back.
// ----------------------------------------------------------------------------

module tb_round_robin_task_ring_unit;
    import rrtr_pkg::*;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    round_robin_task_ring_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // local copy of the ring
    logic [TASK_W-1:0] succ_tbl   [NUM_TASKS];
    logic [TASK_W-1:0] pred_tbl   [NUM_TASKS];
    logic              linked_tbl [NUM_TASKS] = '{default: 1'b0};
    logic [TASK_W-1:0] cur_task   = '0;
    logic              ring_live  = 1'b0;

    out_t expected_results [$];
    out_t want;
    int   mismatch_count = 0;
    bit   src_idle_on    = 1'b1;
    bit   sink_idle_on   = 1'b1;
    int   hold_cycles    = 0;

    function automatic out_t predict_ring_op(in_t req);
        logic [TASK_W-1:0] t;
        logic [TASK_W-1:0] c;
        logic [TASK_W-1:0] n;
        logic [TASK_W-1:0] p;
        logic [TASK_W-1:0] succ_cur;
        logic              is_linked;
        status_t           sts;
        out_t              res;
        t         = req.task_id;
        is_linked = (int'(t) < NUM_TASKS) && linked_tbl[t];
        sts       = STS_DONE;
        case (req.opcode)
            OP_SCHEDULE: begin
                if (ring_live) cur_task = succ_tbl[cur_task];
                else sts = STS_NOOP;
            end
            OP_RUNNABLE: begin
                if (int'(t) >= NUM_TASKS || is_linked) begin
                    sts = STS_NOOP;
                end else if (!ring_live) begin
                    succ_tbl[t]   = t;
                    pred_tbl[t]   = t;
                    linked_tbl[t] = 1'b1;
                    cur_task      = t;
                    ring_live     = 1'b1;
                end else begin
                    c             = cur_task;
                    n             = succ_tbl[c];
                    pred_tbl[t]   = c;
                    succ_tbl[t]   = n;
                    pred_tbl[n]   = t;
                    succ_tbl[c]   = t;
                    linked_tbl[t] = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!is_linked) begin
                    sts = STS_NOOP;
                end else begin
                    succ_cur      = succ_tbl[cur_task];
                    p             = pred_tbl[t];
                    n             = succ_tbl[t];
                    succ_tbl[p]   = n;
                    pred_tbl[n]   = p;
                    linked_tbl[t] = 1'b0;
                    if (cur_task == t) begin
                        if (succ_cur == t) begin
                            ring_live = 1'b0;
                            cur_task  = '0;
                        end else begin
                            cur_task = succ_cur;
                        end
                    end
                end
            end
            default: begin
                sts = is_linked ? STS_DONE : STS_ERROR;
            end
        endcase
        res.current_task  = ring_live ? cur_task : '0;
        res.ring_nonempty = ring_live;
        res.status        = sts;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // result checking and prediction on each accepted transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_data));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.current_task !== want.current_task)
                        report_mismatch($sformatf("current_task got %0d wanted %0d",
                            m_data.current_task, want.current_task));
                    if (m_data.ring_nonempty !== want.ring_nonempty)
                        report_mismatch($sformatf("ring_nonempty got %0b wanted %0b",
                            m_data.ring_nonempty, want.ring_nonempty));
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d wanted %0d",
                            m_data.status, want.status));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_ring_op(s_data));
            end
        end
    end

    // receiver side: random idling and long hold-offs
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (sink_idle_on) begin
            m_ready <= ($urandom_range(99) >= 21);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // called and returns at a falling edge
    task automatic send_op(input opcode_t op, input logic [TASK_W-1:0] id);
        if (src_idle_on) begin
            while ($urandom_range(99) < 21) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, task_id: id};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [TASK_W-1:0] rand_task();
        return TASK_W'($urandom_range(NUM_TASKS - 1));
    endfunction

    task automatic test_directed_cases();
        send_op(OP_SCHEDULE, 4'd0);
        send_op(OP_REMOVE,   4'd15);
        send_op(OP_YIELD,    4'd0);
        send_op(OP_RUNNABLE, 4'd15);
        send_op(OP_SCHEDULE, 4'd9);
        send_op(OP_YIELD,    4'd15);
        send_op(OP_RUNNABLE, 4'd15);
        send_op(OP_REMOVE,   4'd15);
        send_op(OP_SCHEDULE, 4'd15);
        send_op(OP_YIELD,    4'd15);
        send_op(OP_RUNNABLE, 4'd0);
        send_op(OP_RUNNABLE, 4'd5);
        send_op(OP_RUNNABLE, 4'd10);
        send_op(OP_SCHEDULE, 4'd0);
        send_op(OP_SCHEDULE, 4'd0);
        send_op(OP_SCHEDULE, 4'd0);
        send_op(OP_REMOVE,   cur_task);
        send_op(OP_REMOVE,   4'd5);
        send_op(OP_YIELD,    4'd3);
        send_op(OP_REMOVE,   4'd3);
        send_op(OP_SCHEDULE, 4'd0);
        send_op(OP_REMOVE,   4'd10);
        send_op(OP_REMOVE,   4'd0);
        send_op(OP_SCHEDULE, 4'd0);
    endtask

    task automatic test_fill_and_empty();
        logic [TASK_W-1:0] order [NUM_TASKS];
        logic [TASK_W-1:0] tmp;
        int                j;
        for (int i = 0; i < NUM_TASKS; i++) order[i] = TASK_W'(i);
        for (int i = NUM_TASKS - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NUM_TASKS; i++) send_op(OP_RUNNABLE, order[i]);
        send_op(OP_RUNNABLE, rand_task());
        for (int i = 0; i < 20; i++) send_op(OP_SCHEDULE, rand_task());
        for (int i = 0; i < NUM_TASKS; i++) begin
            if ($urandom_range(3) == 0) send_op(OP_REMOVE, cur_task);
            else send_op(OP_REMOVE, order[i]);
        end
        send_op(OP_SCHEDULE, rand_task());
    endtask

    task automatic test_random_traffic(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_op(OP_RUNNABLE, rand_task());
            end else if (pick < 55) begin
                if (ring_live && $urandom_range(2) == 0) send_op(OP_REMOVE, cur_task);
                else send_op(OP_REMOVE, rand_task());
            end else if (pick < 80) begin
                send_op(OP_SCHEDULE, rand_task());
            end else begin
                send_op(OP_YIELD, rand_task());
            end
        end
    endtask

    task automatic test_output_stall();
        src_idle_on = 1'b0;
        @(posedge aclk);
        hold_cycles = 80;
        @(negedge aclk);
        test_random_traffic(12);
        src_idle_on = 1'b1;
    endtask

    task automatic test_input_pause();
        test_random_traffic(30);
        wait_results_drained();
        test_random_traffic(30);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_fill_and_empty();
        test_random_traffic(700);
        test_output_stall();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_traffic(300);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_input_pause();
        test_fill_and_empty();
        test_random_traffic(550);

        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/rrtr_pkg.sv
src/rrtr_datapath.sv
src/rrtr_ctrl.sv
src/round_robin_task_ring_unit.sv
dv/tb_round_robin_task_ring_unit.sv
